### rtl/bpl_pkg.sv
// shared types, codes and constants for the bracket program loader
// no dependencies; compiled first
package bpl_pkg;

   localparam int DEF_CODE_DEPTH  = 4096;
   localparam int DEF_LABEL_DEPTH = 256;

   // fixed field widths of the channel words
   localparam int EVENT_W = 3;
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 13;
   localparam int LABEL_W = 8;
   localparam int COUNT_W = 9;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

   typedef enum logic [EVENT_W-1:0] {
      EV_IGNORED,
      EV_OP,
      EV_OPEN,
      EV_CLOSE_OK,
      EV_CLOSE_BAD,
      EV_END
   } bpl_event_type;

   typedef struct packed {
      bpl_event_type       event_res;
      logic [CHAR_W-1:0]   op_code;
      logic [POS_W-1:0]    code_position;
      logic [LABEL_W-1:0]  label_index;
      logic [POS_W-1:0]    open_position;
      logic [POS_W-1:0]    code_size;
      logic [COUNT_W-1:0]  label_count;
      logic                open_unmatched;
      logic                close_unmatched;
      logic                overflow;
   } bpl_rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } bpl_stack_op_type;

   function automatic logic is_operator(input logic [CHAR_W-1:0] ch);
      return ch inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE};
   endfunction

endpackage

### rtl/bpl_if.sv
// valid/ready channel interfaces for source words and result words
// depends on bpl_pkg
interface bpl_req_if;
   import bpl_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, cmd, char_in, input ready);
   modport sink (input valid, cmd, char_in, output ready);
endinterface

interface bpl_rsp_if;
   import bpl_pkg::*;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;
   logic [CHAR_W-1:0]  op_code;
   logic [POS_W-1:0]   code_position;
   logic [LABEL_W-1:0] label_index;
   logic [POS_W-1:0]   open_position;
   logic [POS_W-1:0]   code_size;
   logic [COUNT_W-1:0] label_count;
   logic               open_unmatched;
   logic               close_unmatched;
   logic               overflow;

   modport source (output valid, event_res, op_code, code_position, label_index,
                   open_position, code_size, label_count, open_unmatched,
                   close_unmatched, overflow, input ready);
   modport sink (input valid, event_res, op_code, code_position, label_index,
                 open_position, code_size, label_count, open_unmatched,
                 close_unmatched, overflow, output ready);
endinterface

### rtl/bracket_program_loader.sv
// bracket program loader: one source word per cycle while the result buffer has room,
// one result word per source word; each result word is registered in the result buffer
// throughput: one word per cycle while the result buffer has room; the stack top register and a forwarded
//    below-top entry let a pop follow any push or pop despite the ram's registered read
// reset: synchronous, clears counts, flags, stack depth and the result buffer
// depends on bpl_pkg, bpl_if, bpl_stack, bpl_rsp_buf
module bracket_program_loader #(
   parameter int CODE_DEPTH  = bpl_pkg::DEF_CODE_DEPTH,
   parameter int LABEL_DEPTH = bpl_pkg::DEF_LABEL_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   bpl_req_if.sink   req_if,
   bpl_rsp_if.source rsp_if
);
   import bpl_pkg::*;

   localparam int PW  = $clog2(CODE_DEPTH + 1);
   localparam int LW  = $clog2(LABEL_DEPTH);
   localparam int LCW = $clog2(LABEL_DEPTH + 1);
   localparam int EW  = LW + PW;

   logic [PW-1:0]    op_count_ff, op_count_in;
   logic [LCW-1:0]   label_ff, label_in;
   logic             close_err_ff, close_err_in;
   logic             ovf_ff, ovf_in;
   logic             accept;
   logic             can_accept;
   bpl_rsp_type      rsp_word;
   bpl_stack_op_type stack_op;
   logic [EW-1:0]    push_entry;
   logic [EW-1:0]    top_entry;
   logic [LCW-1:0]   depth;

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;

   always_comb begin
      op_count_in  = op_count_ff;
      label_in     = label_ff;
      close_err_in = close_err_ff;
      ovf_in       = ovf_ff;
      stack_op     = '0;
      push_entry   = {label_ff[LW-1:0], op_count_ff + PW'(1)};
      rsp_word     = '0;
      rsp_word.event_res = EV_IGNORED;
      if (req_if.cmd == CMD_END) begin
         rsp_word.event_res      = EV_END;
         rsp_word.code_size      = POS_W'(op_count_ff);
         rsp_word.label_count    = COUNT_W'(label_ff);
         rsp_word.open_unmatched = (depth != '0);
         op_count_in    = '0;
         label_in       = '0;
         close_err_in   = 1'b0;
         ovf_in         = 1'b0;
         stack_op.clear = 1'b1;
      end else if (!is_operator(req_if.char_in)) begin
         rsp_word.event_res = EV_IGNORED;
      end else if (op_count_ff == PW'(CODE_DEPTH)) begin
         // code store full: operator dropped
         ovf_in = 1'b1;
      end else begin
         op_count_in            = op_count_ff + PW'(1);
         rsp_word.event_res     = EV_OP;
         rsp_word.op_code       = req_if.char_in;
         rsp_word.code_position = POS_W'(op_count_in);
         if (req_if.char_in == CH_OPEN) begin
            if (label_ff == LCW'(LABEL_DEPTH) || depth == LCW'(LABEL_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               stack_op.push        = 1'b1;
               rsp_word.event_res   = EV_OPEN;
               rsp_word.label_index = LABEL_W'(label_ff);
               label_in             = label_ff + LCW'(1);
            end
         end else if (req_if.char_in == CH_CLOSE) begin
            if (depth != '0) begin
               stack_op.pop           = 1'b1;
               rsp_word.event_res     = EV_CLOSE_OK;
               rsp_word.label_index   = LABEL_W'(top_entry[EW-1:PW]);
               rsp_word.open_position = POS_W'(top_entry[PW-1:0]);
            end else begin
               close_err_in       = 1'b1;
               rsp_word.event_res = EV_CLOSE_BAD;
            end
         end
      end
      // end report shows the flags as they stood before clearing
      rsp_word.close_unmatched = (req_if.cmd == CMD_END) ? close_err_ff : close_err_in;
      rsp_word.overflow        = (req_if.cmd == CMD_END) ? ovf_ff : ovf_in;
      if (!accept) begin
         stack_op = '0;
      end
   end

   bpl_stack #(
      .ENTRY_W (EW),
      .DEPTH   (LABEL_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .op         (stack_op),
      .push_entry (push_entry),
      .top        (top_entry),
      .depth      (depth)
   );

   bpl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (rsp_word),
      .can_accept (can_accept),
      .rsp_if     (rsp_if)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_count_ff  <= '0;
         label_ff     <= '0;
         close_err_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else if (accept) begin
         op_count_ff  <= op_count_in;
         label_ff     <= label_in;
         close_err_ff <= close_err_in;
         ovf_ff       <= ovf_in;
      end
   end
endmodule

### rtl/bpl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/bpl_stack.sv
// open-bracket stack: top entry in a register, the rest in bpl_ram
// depends on bpl_pkg and bpl_ram
module bpl_stack #(
   parameter int ENTRY_W = 21,
   parameter int DEPTH   = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bpl_pkg::bpl_stack_op_type     op,
   input  logic [ENTRY_W-1:0]            push_entry,
   output logic [ENTRY_W-1:0]            top,
   output logic [$clog2(DEPTH+1)-1:0]    depth
);
   import bpl_pkg::*;

   localparam int DW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [DW-1:0]      depth_ff, depth_in;
   logic [ENTRY_W-1:0] top_ff, top_in;
   logic [ENTRY_W-1:0] fwd_ff, fwd_in;
   logic               fwd_sel_ff, fwd_sel_in;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [ENTRY_W-1:0] below;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [DW-1:0]      rd_index;

   // entry just under the top; forwarded when it was written last cycle
   assign below = fwd_sel_ff ? fwd_ff : ram_rd_data;

   always_comb begin
      depth_in    = depth_ff;
      top_in      = top_ff;
      fwd_in      = fwd_ff;
      fwd_sel_in  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(depth_ff - DW'(1));
      if (op.clear) begin
         depth_in = '0;
      end else if (op.push) begin
         depth_in   = depth_ff + DW'(1);
         top_in     = push_entry;
         ram_wr_en  = (depth_ff != '0);
         fwd_in     = top_ff;
         fwd_sel_in = 1'b1;
      end else if (op.pop) begin
         depth_in = depth_ff - DW'(1);
         top_in   = below;
      end
   end

   // prefetch the entry that will sit under the next top
   assign rd_index = depth_in - DW'(2);

   bpl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         fwd_sel_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         fwd_sel_ff <= fwd_sel_in;
      end
      top_ff <= top_in;
      fwd_ff <= fwd_in;
   end

   assign top   = top_ff;
   assign depth = depth_ff;
endmodule

### rtl/bpl_rsp_buf.sv
// two-word result buffer: output register plus skid slot
// depends on bpl_pkg and bpl_rsp_if
module bpl_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bpl_pkg::bpl_rsp_type push_data,
   output logic                 can_accept,
   bpl_rsp_if.source            rsp_if
);
   import bpl_pkg::*;

   logic [1:0]  count_ff, count_in;
   bpl_rsp_type slot0_ff, slot0_in;
   bpl_rsp_type slot1_ff, slot1_in;
   logic        pop;

   assign pop        = rsp_if.valid && rsp_if.ready;
   assign can_accept = (count_ff != 2'd2);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         slot0_in = (count_ff == 2'd2) ? slot1_ff : push_data;
      end
      if (push && count_ff == 2'd0) begin
         slot0_in = push_data;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         slot1_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_if.valid           = (count_ff != 2'd0);
   assign rsp_if.event_res       = slot0_ff.event_res;
   assign rsp_if.op_code         = slot0_ff.op_code;
   assign rsp_if.code_position   = slot0_ff.code_position;
   assign rsp_if.label_index     = slot0_ff.label_index;
   assign rsp_if.open_position   = slot0_ff.open_position;
   assign rsp_if.code_size       = slot0_ff.code_size;
   assign rsp_if.label_count     = slot0_ff.label_count;
   assign rsp_if.open_unmatched  = slot0_ff.open_unmatched;
   assign rsp_if.close_unmatched = slot0_ff.close_unmatched;
   assign rsp_if.overflow        = slot0_ff.overflow;
endmodule

### rtl/bpl_checker.sv
// port-level checks for the bracket program loader, bound to the top level
// depends on bpl_pkg and bracket_program_loader
module bpl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bpl_pkg::EVENT_W-1:0] rsp_event_res
);
   import bpl_pkg::*;

   // result buffer comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a word taken while no result is pending shows up the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> rsp_valid)
      else $error("result missing one cycle after word taken");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res <= EV_END))
      else $error("event code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_res)))
      else $error("stalled result changed");
endmodule

bind bracket_program_loader bpl_checker u_bpl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_event_res (rsp_if.event_res)
);
